FILE: hdl/rpfa_pkg.sv
// Package for the reference-counted page frame allocator.
// Holds pool sizes, request and status codes, FSM states and control structs.
// No dependencies.
package rpfa_pkg;

    localparam int ADDR_W      = 56;
    localparam int PAGE_SHIFT  = 12;
    localparam int NUM_FRAMES  = 1024;
    localparam int IDX_W       = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int CNT_W       = $clog2(NUM_FRAMES + 1);
    localparam int REF_BITS    = 16;
    localparam int REF_OUT_W   = 16;
    localparam int REQ_W       = 2;
    localparam int STATUS_W    = 3;
    localparam int PAGE_NUM_W  = ADDR_W - PAGE_SHIFT;

    localparam logic [REF_BITS-1:0] REF_MAX        = '1;
    localparam logic [ADDR_W-1:0]   FRAME_BASE_RST = ADDR_W'(64'h8000_0000);

    typedef enum logic [REQ_W-1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_SHARE = 2'd2,
        REQ_QUERY = 2'd3
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_OOM        = 3'd1,
        ST_MISALIGNED = 3'd2,
        ST_RANGE      = 3'd3,
        ST_NOREF      = 3'd4,
        ST_SAT        = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic clr_en;
        logic accept;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic out_free;
    } sts_t;

endpackage

FILE: hdl/rpfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rpfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/rpfa_ctrl.sv
// Controller state machine of the page frame allocator.
// Depends on rpfa_pkg for states and the command and status structs.
module rpfa_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rpfa_pkg::sts_t    sts,
    output rpfa_pkg::cmd_t    cmd
);

    rpfa_pkg::state_t state_reg;
    rpfa_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rpfa_pkg::S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rpfa_pkg::S_CLEAR: begin
                if (sts.clear_done) begin
                    state_next = rpfa_pkg::S_IDLE;
                end
            end
            rpfa_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = rpfa_pkg::S_EXEC;
                end
            end
            rpfa_pkg::S_EXEC: begin
                if (sts.out_free) begin
                    state_next = rpfa_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = rpfa_pkg::S_CLEAR;
            end
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            rpfa_pkg::S_CLEAR: begin
                cmd.clr_en = 1'b1;
            end
            rpfa_pkg::S_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            rpfa_pkg::S_EXEC: begin
                cmd.commit = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: hdl/rpfa_datapath.sv
// Datapath of the page frame allocator: base register, address check,
// count and stack memories, free count and the result register.
// Depends on rpfa_pkg and rpfa_ram.
module rpfa_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  rpfa_pkg::cmd_t                      cmd,
    output rpfa_pkg::sts_t                      sts,
    input  logic                                cfg_wr_en,
    input  logic [rpfa_pkg::ADDR_W-1:0]         cfg_wr_data,
    input  logic [rpfa_pkg::REQ_W-1:0]          s_req_type,
    input  logic [rpfa_pkg::ADDR_W-1:0]         s_page_addr,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [rpfa_pkg::ADDR_W-1:0]         m_frame_addr,
    output logic [rpfa_pkg::REF_OUT_W-1:0]      m_ref_count,
    output logic [rpfa_pkg::STATUS_W-1:0]       m_status
);

    logic [rpfa_pkg::ADDR_W-1:0]    frame_base_reg;
    logic [rpfa_pkg::CNT_W-1:0]     free_count_reg;
    logic [rpfa_pkg::CNT_W-1:0]     free_count_next;
    logic [rpfa_pkg::CNT_W-1:0]     min_count_reg;
    logic [rpfa_pkg::CNT_W-1:0]     min_count_next;
    logic [rpfa_pkg::IDX_W-1:0]     clr_addr_reg;
    rpfa_pkg::req_t                 req_reg;
    rpfa_pkg::status_t              loc_st_reg;
    rpfa_pkg::status_t              loc_st;
    logic [rpfa_pkg::IDX_W-1:0]     idx_reg;

    logic                           m_valid_reg;
    logic [rpfa_pkg::ADDR_W-1:0]    m_frame_addr_reg;
    logic [rpfa_pkg::ADDR_W-1:0]    m_frame_addr_next;
    logic [rpfa_pkg::REF_BITS-1:0]  m_cnt_reg;
    logic [rpfa_pkg::REF_BITS-1:0]  m_cnt_next;
    rpfa_pkg::status_t              m_status_reg;
    rpfa_pkg::status_t              m_status_next;

    logic [rpfa_pkg::ADDR_W:0]      diff;
    logic [rpfa_pkg::IDX_W-1:0]     in_idx;
    logic [rpfa_pkg::IDX_W-1:0]     top_pos;
    logic [rpfa_pkg::IDX_W-1:0]     pop_idx;

    logic                           ref_we;
    logic [rpfa_pkg::IDX_W-1:0]     ref_waddr;
    logic [rpfa_pkg::REF_BITS-1:0]  ref_wdata;
    logic [rpfa_pkg::REF_BITS-1:0]  ref_rdata;
    logic                           stk_we;
    logic [rpfa_pkg::IDX_W-1:0]     stk_rdata;

    logic                           op_ref_we;
    logic [rpfa_pkg::IDX_W-1:0]     op_ref_waddr;
    logic [rpfa_pkg::REF_BITS-1:0]  op_ref_wdata;
    logic [rpfa_pkg::REF_BITS-1:0]  cnt_dec;

    // Address check at accept time; the borrow bit flags an address below the base.
    assign diff   = {1'b0, s_page_addr} - {1'b0, frame_base_reg};
    assign in_idx = diff[rpfa_pkg::PAGE_SHIFT +: rpfa_pkg::IDX_W];

    always_comb begin
        if (s_page_addr[rpfa_pkg::PAGE_SHIFT-1:0] != '0) begin
            loc_st = rpfa_pkg::ST_MISALIGNED;
        end else if (diff[rpfa_pkg::ADDR_W]) begin
            loc_st = rpfa_pkg::ST_RANGE;
        end else if (diff[rpfa_pkg::ADDR_W-1:rpfa_pkg::PAGE_SHIFT]
                     >= rpfa_pkg::PAGE_NUM_W'(rpfa_pkg::NUM_FRAMES)) begin
            loc_st = rpfa_pkg::ST_RANGE;
        end else begin
            loc_st = rpfa_pkg::ST_OK;
        end
    end

    assign top_pos = rpfa_pkg::IDX_W'(free_count_reg - rpfa_pkg::CNT_W'(1));

    // Slots below the lowest fill level ever reached were never written; pop their position.
    assign pop_idx = ({1'b0, top_pos} < rpfa_pkg::CNT_W'(min_count_reg)) ? top_pos
                                                                          : stk_rdata;
    assign cnt_dec = ref_rdata - rpfa_pkg::REF_BITS'(1);

    always_comb begin
        m_frame_addr_next = '0;
        m_cnt_next        = '0;
        m_status_next     = rpfa_pkg::ST_OK;
        free_count_next   = free_count_reg;
        min_count_next    = min_count_reg;
        op_ref_we         = 1'b0;
        op_ref_waddr      = idx_reg;
        op_ref_wdata      = '0;
        stk_we            = 1'b0;
        if (req_reg == rpfa_pkg::REQ_ALLOC) begin
            if (free_count_reg == '0) begin
                m_status_next = rpfa_pkg::ST_OOM;
            end else begin
                free_count_next   = free_count_reg - rpfa_pkg::CNT_W'(1);
                if (free_count_next < min_count_reg) begin
                    min_count_next = free_count_next;
                end
                op_ref_we         = 1'b1;
                op_ref_waddr      = pop_idx;
                op_ref_wdata      = rpfa_pkg::REF_BITS'(1);
                m_cnt_next        = rpfa_pkg::REF_BITS'(1);
                m_frame_addr_next = frame_base_reg
                                  + {rpfa_pkg::PAGE_NUM_W'(pop_idx),
                                     rpfa_pkg::PAGE_SHIFT'(0)};
            end
        end else if (loc_st_reg != rpfa_pkg::ST_OK) begin
            m_status_next = loc_st_reg;
        end else begin
            m_cnt_next = ref_rdata;
            case (req_reg)
                rpfa_pkg::REQ_FREE: begin
                    if (ref_rdata == '0) begin
                        m_status_next = rpfa_pkg::ST_NOREF;
                    end else begin
                        m_cnt_next   = cnt_dec;
                        op_ref_we    = 1'b1;
                        op_ref_wdata = cnt_dec;
                        if (cnt_dec == '0 && free_count_reg
                                < rpfa_pkg::CNT_W'(rpfa_pkg::NUM_FRAMES)) begin
                            stk_we          = 1'b1;
                            free_count_next = free_count_reg + rpfa_pkg::CNT_W'(1);
                        end
                    end
                end
                rpfa_pkg::REQ_SHARE: begin
                    if (ref_rdata == '0) begin
                        m_status_next = rpfa_pkg::ST_NOREF;
                    end else if (ref_rdata == rpfa_pkg::REF_MAX) begin
                        m_status_next = rpfa_pkg::ST_SAT;
                    end else begin
                        m_cnt_next   = ref_rdata + rpfa_pkg::REF_BITS'(1);
                        op_ref_we    = 1'b1;
                        op_ref_wdata = ref_rdata + rpfa_pkg::REF_BITS'(1);
                    end
                end
                default: begin
                    m_cnt_next = ref_rdata;
                end
            endcase
        end
    end

    assign ref_we    = cmd.clr_en | (cmd.commit & op_ref_we);
    assign ref_waddr = cmd.clr_en ? clr_addr_reg : op_ref_waddr;
    assign ref_wdata = cmd.clr_en ? '0 : op_ref_wdata;

    rpfa_ram #(
        .WIDTH (rpfa_pkg::REF_BITS),
        .DEPTH (rpfa_pkg::NUM_FRAMES)
    ) u_ref_ram (
        .aclk  (aclk),
        .we    (ref_we),
        .waddr (ref_waddr),
        .wdata (ref_wdata),
        .re    (cmd.accept),
        .raddr (in_idx),
        .rdata (ref_rdata)
    );

    rpfa_ram #(
        .WIDTH (rpfa_pkg::IDX_W),
        .DEPTH (rpfa_pkg::NUM_FRAMES)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (cmd.commit & stk_we),
        .waddr (free_count_reg[rpfa_pkg::IDX_W-1:0]),
        .wdata (idx_reg),
        .re    (cmd.accept),
        .raddr (top_pos),
        .rdata (stk_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_base_reg <= rpfa_pkg::FRAME_BASE_RST;
            free_count_reg <= rpfa_pkg::CNT_W'(rpfa_pkg::NUM_FRAMES);
            min_count_reg  <= rpfa_pkg::CNT_W'(rpfa_pkg::NUM_FRAMES);
            clr_addr_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                frame_base_reg <= cfg_wr_data;
            end
            if (cmd.clr_en) begin
                clr_addr_reg <= clr_addr_reg + rpfa_pkg::IDX_W'(1);
            end
            if (cmd.commit) begin
                free_count_reg <= free_count_next;
                min_count_reg  <= min_count_next;
                m_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            req_reg    <= rpfa_pkg::req_t'(s_req_type);
            loc_st_reg <= loc_st;
            idx_reg    <= in_idx;
        end
        if (cmd.commit) begin
            m_frame_addr_reg <= m_frame_addr_next;
            m_cnt_reg        <= m_cnt_next;
            m_status_reg     <= m_status_next;
        end
    end

    assign sts.clear_done = (clr_addr_reg == rpfa_pkg::IDX_W'(rpfa_pkg::NUM_FRAMES - 1));
    assign sts.out_free   = ~m_valid_reg | m_ready;

    assign m_valid      = m_valid_reg;
    assign m_frame_addr = m_frame_addr_reg;
    assign m_ref_count  = rpfa_pkg::REF_OUT_W'(m_cnt_reg);
    assign m_status     = m_status_reg;

endmodule

FILE: hdl/refcounted_page_frame_allocator_core.sv
// A result waits in an output register. A request is accepted in S_IDLE and commits
// in S_EXEC once that register is free. A new request is taken only after the last
// has read and written back the count and stack memories.
// Reset: synchronous active-low; afterwards a clearing pass zeroes the count memory
// while s_ready stays low. Configuration writes are taken throughout.
// Depends on rpfa_pkg, rpfa_ctrl and rpfa_datapath.
module refcounted_page_frame_allocator_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [rpfa_pkg::ADDR_W-1:0]       cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [rpfa_pkg::REQ_W-1:0]        s_req_type,
    input  logic [rpfa_pkg::ADDR_W-1:0]       s_page_addr,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [rpfa_pkg::ADDR_W-1:0]       m_frame_addr,
    output logic [rpfa_pkg::REF_OUT_W-1:0]    m_ref_count,
    output logic [rpfa_pkg::STATUS_W-1:0]     m_status
);

    rpfa_pkg::cmd_t cmd;
    rpfa_pkg::sts_t sts;

    rpfa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    rpfa_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_req_type   (s_req_type),
        .s_page_addr  (s_page_addr),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_frame_addr (m_frame_addr),
        .m_ref_count  (m_ref_count),
        .m_status     (m_status)
    );

endmodule
